>>> hw/rtl/rid_alloc_pkg.sv
// Shared constants and status codes for the recycling identifier allocator.
package rid_alloc_pkg;

    // Default window size and register reset value
    localparam int unsigned CAPACITY_DEF   = 1024;
    localparam logic [31:0] FIRST_ID_RESET = 32'd10000;

    // Identifiers at or above this value are never issued
    localparam logic [31:0] ID_LIMIT       = 32'hFFFF_FFFF;

    // Result status codes
    localparam logic [1:0]  ST_OK          = 2'd0;
    localparam logic [1:0]  ST_EXHAUSTED   = 2'd1;
    localparam logic [1:0]  ST_NOT_IN_USE  = 2'd2;

endpackage

>>> hw/rtl/recycling_id_allocator.sv
// Identifier allocator: LIFO reuse of released identifiers, fresh issue from a base register.
// A request is captured in the stage-1 register, then resolved into the result register;
// the result is then on the output ports, marked by o_done.
// Throughput: one request per cycle; busy stays low and results are never held off, the
// two-stage pipe takes a request every cycle, with in-use map bypass and a stack-top cache.
// Reset (synchronous, active low) clears counts, pipe valids and loads first_id with 10000;
// the in-use map needs no clearing pass, slots at or above the fresh counter read as free.
module recycling_id_allocator #(
    parameter int unsigned CAPACITY = rid_alloc_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [31:0] i_release_id,
    // result channel
    output logic        o_done,
    output logic [31:0] o_assigned_id,
    output logic [1:0]  o_status,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    import rid_alloc_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    // Storage
    logic [AW-1:0] r_stack_mem [CAPACITY];
    logic          r_map_mem   [CAPACITY];

    // Configuration
    logic [31:0]   r_first_id;

    // Stage 1 (input register)
    logic          r_vld;
    logic          r_kind;
    logic          r_in_win;
    logic [AW-1:0] r_slot;
    logic          r_map_rd;
    logic          r_fwd_hit;
    logic          r_fwd_val;

    // Allocator state
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_next_fresh;
    logic [AW-1:0] r_top0;
    logic [AW-1:0] r_top1;
    logic          r_top1_from_rd;
    logic [AW-1:0] r_stk_rd;

    // Result register
    logic          r_done;
    logic [31:0]   r_id;
    logic [1:0]    r_status;

    // Combinational
    logic          w_accept;
    logic [32:0]   w_rel_diff;
    logic          w_rel_in_win;
    logic [AW-1:0] w_rel_slot;
    logic          w_has_stack;
    logic          w_has_fresh;
    logic [AW-1:0] w_alloc_slot;
    logic [32:0]   w_id_sum;
    logic          w_alloc_ok;
    logic          w_map_bit;
    logic          w_rel_ok;
    logic          w_push;
    logic          w_pop;
    logic          w_fresh;
    logic [AW-1:0] w_top1;
    logic [CW-1:0] w_rd_ptr;
    logic [AW-1:0] w_rd_addr;
    logic          w_map_we;
    logic [AW-1:0] w_map_waddr;
    logic          w_map_wdata;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;

    // Map the released identifier onto a window slot
    assign w_rel_diff   = {1'b0, i_release_id} - {1'b0, r_first_id};
    assign w_rel_in_win = !w_rel_diff[32] && (w_rel_diff[31:0] < 32'(CAPACITY));
    assign w_rel_slot   = w_rel_diff[AW-1:0];

    // Pick the slot to issue: stack top first, then the fresh counter
    assign w_has_stack  = (r_count != '0);
    assign w_has_fresh  = (r_next_fresh < CW'(CAPACITY));
    assign w_alloc_slot = w_has_stack ? r_top0 : r_next_fresh[AW-1:0];
    assign w_id_sum     = {1'b0, r_first_id} + 33'(w_alloc_slot);
    assign w_alloc_ok   = r_vld && !r_kind && (w_has_stack || w_has_fresh)
                          && (w_id_sum < {1'b0, ID_LIMIT});

    // Check the in-use bit, with bypass of the write made at the read edge
    assign w_map_bit = r_fwd_hit ? r_fwd_val : r_map_rd;
    assign w_rel_ok  = r_vld && r_kind && r_in_win
                       && (CW'(r_slot) < r_next_fresh) && w_map_bit
                       && (r_count < CW'(CAPACITY));

    assign w_push  = w_rel_ok;
    assign w_pop   = w_alloc_ok && w_has_stack;
    assign w_fresh = w_alloc_ok && !w_has_stack;

    // Second stack entry comes from the memory read right after a pop
    assign w_top1    = r_top1_from_rd ? r_stk_rd : r_top1;
    assign w_rd_ptr  = r_count - CW'(3);
    assign w_rd_addr = w_rd_ptr[AW-1:0];

    assign w_map_we    = w_alloc_ok || w_rel_ok;
    assign w_map_waddr = w_alloc_ok ? w_alloc_slot : r_slot;
    assign w_map_wdata = w_alloc_ok;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_id <= FIRST_ID_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_first_id <= i_cfg_data;
        end
    end

    // Capture the transaction and read its in-use bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            r_vld     <= w_accept;
            r_fwd_hit <= w_map_we && (w_map_waddr == w_rel_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_val <= w_map_wdata;
        if (w_accept) begin
            r_kind   <= i_kind;
            r_in_win <= w_rel_in_win;
            r_slot   <= w_rel_slot;
            r_map_rd <= r_map_mem[w_rel_slot];
        end
    end

    // Update the in-use map
    always_ff @(posedge i_clk) begin
        if (w_map_we) begin
            r_map_mem[w_map_waddr] <= w_map_wdata;
        end
    end

    // Free stack memory: push at the count, prefetch below the cached top pair
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_stack_mem[r_count[AW-1:0]] <= r_slot;
        end
        r_stk_rd <= r_stack_mem[w_rd_addr];
    end

    // Advance counters and the stack-top cache
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_next_fresh   <= '0;
            r_top1_from_rd <= 1'b0;
        end else begin
            if (w_push) begin
                r_count        <= r_count + CW'(1);
                r_top1_from_rd <= 1'b0;
            end else if (w_pop) begin
                r_count        <= r_count - CW'(1);
                r_top1_from_rd <= 1'b1;
            end else begin
                r_top1_from_rd <= 1'b0;
            end
            if (w_fresh) begin
                r_next_fresh <= r_next_fresh + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_top0 <= r_slot;
            r_top1 <= r_top0;
        end else if (w_pop) begin
            r_top0 <= w_top1;
        end else begin
            r_top1 <= w_top1;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vld) begin
            r_id <= w_alloc_ok ? w_id_sum[31:0] : 32'd0;
            if (r_kind) begin
                r_status <= w_rel_ok ? ST_OK : ST_NOT_IN_USE;
            end else begin
                r_status <= w_alloc_ok ? ST_OK : ST_EXHAUSTED;
            end
        end
    end

    assign o_done        = r_done;
    assign o_assigned_id = r_id;
    assign o_status      = r_status;

endmodule

>>> hw/rtl/rid_alloc_chk.sv
// Port-level checker for the recycling identifier allocator, bound to the top level.
module rid_alloc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_kind,
    input logic [31:0] i_release_id,
    input logic        o_done,
    input logic [31:0] o_assigned_id,
    input logic [1:0]  o_status,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [31:0] i_cfg_data
);
    import rid_alloc_pkg::*;

    // Every accepted transaction yields a result on o_done while reset stays released
    a_result_latency: assert property (@(posedge i_clk)
        (i_rst_n && start && !busy) ##1 i_rst_n |=> o_done)
        else $error("accepted transaction produced no result");

    // A failed transaction hands out no identifier
    a_fail_zero_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_assigned_id == 32'd0))
        else $error("identifier returned with error status");

    // A release never hands out an identifier
    a_release_zero_id: assert property (@(posedge i_clk)
        (i_rst_n && start && !busy && i_kind) ##1 i_rst_n |=> (o_assigned_id == 32'd0))
        else $error("release returned an identifier");

    // Reset drops any pending result
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe after reset");

endmodule

bind recycling_id_allocator rid_alloc_chk u_rid_alloc_chk (.*);
